// ===== rtl/msuf_pkg.sv =====
// Shared types, constants and codes for the maze spanning-tree union-find block.
// No dependencies; every other file of the block but msuf_ram imports this package.
package msuf_pkg;

  // Grid limits and the sizes that follow from them.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int CELLS    = (MAX_ROWS / 2) * (MAX_COLS / 2);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int HALF_C_W = $clog2(MAX_COLS / 2);

  // Field widths.
  localparam int DIM_W   = 7;
  localparam int COORD_W = 6;
  localparam int CNT_W   = 10;
  localparam int RANK_W  = 4;
  localparam int NEED_W  = 2 * (DIM_W - 1);
  localparam int NODE_W  = RANK_W + ADDR_W;

  localparam logic [DIM_W-1:0]   DIM_MIN   = 7'd3;
  localparam logic [DIM_W-1:0]   DIM_RESET = 7'd33;
  localparam logic [DIM_W-1:0]   STEP      = 7'd2;
  localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  // Configuration register indexes.
  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

  // Input function codes.
  typedef enum logic {
    FN_CLEAR = 1'b0,
    FN_EDGE  = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_CLEARED = 3'd0,
    ST_JOINED  = 3'd1,
    ST_SAME    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_DONE    = 3'd4
  } status_e;

  // Sequencer states of the union-find engine.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_RD,
    S_FIND_WALK,
    S_COMP_RD,
    S_COMP_WALK,
    S_JOIN_B,
    S_RESULT
  } state_e;

  // One entry of the disjoint-set table.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ADDR_W-1:0] parent;
  } node_t;

  // Decoded command handed from the front end to the engine.
  typedef struct packed {
    logic               clear;
    logic               bad;
    logic [ADDR_W-1:0]  idx_a;
    logic [ADDR_W-1:0]  idx_b;
    logic [COORD_W-1:0] wall_row;
    logic [COORD_W-1:0] wall_col;
  } cmd_t;

  // Result of one transaction.
  typedef struct packed {
    status_e            status;
    logic [COORD_W-1:0] wall_row;
    logic [COORD_W-1:0] wall_col;
    logic [CNT_W-1:0]   joined_total;
    logic               tree_done;
  } res_t;

  // Table index of the maze cell at a grid row and column.
  function automatic logic [ADDR_W-1:0] cell_index(logic [COORD_W-1:0] row,
                                                   logic [COORD_W-1:0] col);
    cell_index = ADDR_W'({row[COORD_W-1:1], col[HALF_C_W:1]});
  endfunction

endpackage

// ===== rtl/msuf_ifs.sv =====
// Valid/ready channel interfaces for the edge items and the results.
// Depends on msuf_pkg for field widths.
interface msuf_item_if import msuf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] cell_row;
  logic [COORD_W-1:0] cell_col;
  logic               go_down;

  modport source (output valid, func, cell_row, cell_col, go_down, input ready);
  modport sink   (input valid, func, cell_row, cell_col, go_down, output ready);
endinterface

interface msuf_result_if import msuf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [COORD_W-1:0] wall_row;
  logic [COORD_W-1:0] wall_col;
  logic [CNT_W-1:0]   joined_total;
  logic               tree_done;

  modport source (output valid, status, wall_row, wall_col, joined_total, tree_done,
                  input ready);
  modport sink   (input valid, status, wall_row, wall_col, joined_total, tree_done,
                  output ready);
endinterface

// ===== rtl/msuf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module msuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/msuf_engine.sv =====
// Union-find sequencer: clearing sweep, two finds with path compression, union by rank.
// Depends on msuf_pkg and instantiates msuf_ram for the parent/rank table.
module msuf_engine import msuf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cmd_t              cmd_i,
  input  logic [NEED_W-1:0] need_i,
  input  logic              out_free_i,
  output logic              idle_o,
  output logic              res_valid_o,
  output res_t              res_o
);

  state_e             state_q, state_d;
  logic               clr_reply_q, clr_reply_d;
  logic               sel_b_q, sel_b_d;
  logic [ADDR_W-1:0]  node_a_q, node_a_d;
  logic [ADDR_W-1:0]  node_b_q, node_b_d;
  logic [ADDR_W-1:0]  walk_q, walk_d;
  logic [ADDR_W-1:0]  root_q, root_d;
  logic [RANK_W-1:0]  root_rank_q, root_rank_d;
  logic [ADDR_W-1:0]  root_a_q, root_a_d;
  logic [RANK_W-1:0]  rank_a_q, rank_a_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  status_e            status_q, status_d;
  logic [COORD_W-1:0] wall_row_q, wall_row_d;
  logic [COORD_W-1:0] wall_col_q, wall_col_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  node_t             ram_wdata;
  logic [NODE_W-1:0] ram_rdata;
  node_t             rd;

  logic at_root;
  logic walk_done;
  logic same_set;
  logic rank_eq;
  logic cnt_full;
  logic clr_last;

  // Parent/rank table.
  msuf_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CELLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared compares; the read data always belongs to walk_q.
  assign rd        = node_t'(ram_rdata);
  assign at_root   = (rd.parent == walk_q);
  assign walk_done = (walk_q == root_q);
  assign same_set  = (root_a_q == root_q);
  assign rank_eq   = (rank_a_q == root_rank_q);
  assign cnt_full  = ({{(NEED_W - CNT_W){1'b0}}, cnt_q} >= need_i);
  assign clr_last  = (walk_q == ADDR_W'(CELLS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_last) begin
          state_d = clr_reply_q ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          if (cmd_i.clear) begin
            state_d = S_CLEAR;
          end else if (cmd_i.bad || cnt_full) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_FIND_RD;
          end
        end
      end
      S_FIND_RD:   state_d = S_FIND_WALK;
      S_FIND_WALK: begin
        if (at_root) begin
          state_d = S_COMP_RD;
        end
      end
      S_COMP_RD:   state_d = S_COMP_WALK;
      S_COMP_WALK: begin
        if (walk_done) begin
          if (!sel_b_q) begin
            state_d = S_FIND_RD;
          end else if (!same_set && rank_eq) begin
            state_d = S_JOIN_B;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_JOIN_B:    state_d = S_RESULT;
      S_RESULT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    clr_reply_d = clr_reply_q;
    sel_b_d     = sel_b_q;
    node_a_d    = node_a_q;
    node_b_d    = node_b_q;
    walk_d      = walk_q;
    root_d      = root_q;
    root_rank_d = root_rank_q;
    root_a_d    = root_a_q;
    rank_a_d    = rank_a_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    wall_row_d  = wall_row_q;
    wall_col_d  = wall_col_q;
    case (state_q)
      S_CLEAR: begin
        walk_d   = walk_q + ADDR_W'(1);
        status_d = ST_CLEARED;
      end
      S_IDLE: begin
        if (start_i) begin
          node_a_d   = cmd_i.idx_a;
          node_b_d   = cmd_i.idx_b;
          wall_row_d = cmd_i.wall_row;
          wall_col_d = cmd_i.wall_col;
          sel_b_d    = 1'b0;
          walk_d     = cmd_i.idx_a;
          if (cmd_i.clear) begin
            walk_d      = '0;
            clr_reply_d = 1'b1;
            cnt_d       = '0;
          end else if (cmd_i.bad) begin
            status_d = ST_RANGE;
          end else if (cnt_full) begin
            status_d = ST_DONE;
          end
        end
      end
      S_FIND_WALK: begin
        if (at_root) begin
          root_d      = walk_q;
          root_rank_d = rd.rank;
          walk_d      = sel_b_q ? node_b_q : node_a_q;
        end else begin
          walk_d = rd.parent;
        end
      end
      S_COMP_WALK: begin
        if (walk_done) begin
          if (!sel_b_q) begin
            // First find finished: keep its root and start on the target cell.
            root_a_d = root_q;
            rank_a_d = root_rank_q;
            sel_b_d  = 1'b1;
            walk_d   = node_b_q;
          end else if (same_set) begin
            status_d = ST_SAME;
          end else begin
            status_d = ST_JOINED;
            if (cnt_q != CNT_MAX) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end else begin
          walk_d = rd.parent;
        end
      end
      default: begin
      end
    endcase
  end

  // Table accesses and result handshake.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = walk_q;
    ram_wdata   = '{rank: '0, parent: walk_q};
    ram_raddr   = walk_q;
    res_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_FIND_WALK: begin
        ram_raddr = rd.parent;
      end
      S_COMP_WALK: begin
        ram_raddr = rd.parent;
        if (!walk_done) begin
          // Point the node on the path straight at its root.
          ram_we    = 1'b1;
          ram_wdata = '{rank: rd.rank, parent: root_q};
        end else if (sel_b_q && !same_set) begin
          ram_we = 1'b1;
          if (rank_a_q <= root_rank_q) begin
            ram_waddr = root_a_q;
            ram_wdata = '{rank: rank_a_q, parent: root_q};
          end else begin
            ram_waddr = root_q;
            ram_wdata = '{rank: root_rank_q, parent: root_a_q};
          end
        end
      end
      S_JOIN_B: begin
        // Equal ranks: the surviving root's rank grows by one, saturating at RANK_MAX.
        ram_we    = 1'b1;
        ram_waddr = root_q;
        ram_wdata = '{rank: (root_rank_q == RANK_MAX) ? root_rank_q
                                                      : root_rank_q + RANK_W'(1),
                      parent: root_q};
      end
      S_RESULT: begin
        res_valid_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    res_o.status       = status_q;
    res_o.wall_row     = (status_q == ST_JOINED) ? wall_row_q : '0;
    res_o.wall_col     = (status_q == ST_JOINED) ? wall_col_q : '0;
    res_o.joined_total = cnt_q;
    res_o.tree_done    = cnt_full;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_reply_q <= 1'b0;
      sel_b_q     <= 1'b0;
      walk_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_reply_q <= clr_reply_d;
      sel_b_q     <= sel_b_d;
      walk_q      <= walk_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    node_a_q    <= node_a_d;
    node_b_q    <= node_b_d;
    root_q      <= root_d;
    root_rank_q <= root_rank_d;
    root_a_q    <= root_a_d;
    rank_a_q    <= rank_a_d;
    status_q    <= status_d;
    wall_row_q  <= wall_row_d;
    wall_col_q  <= wall_col_d;
  end

endmodule

// ===== rtl/maze_spanning_tree_union_find.sv =====
// Top level of the maze spanning-tree union-find block: configuration, edge checks, output stage.
// Depends on msuf_pkg, msuf_ifs (channel interfaces) and msuf_engine.
//
// Usage: item_i carries one transaction per command. A clear command resets every maze
// cell to its own set; an edge command names an odd interior cell and a direction and is
// joined, reported as same set, rejected as out of range, or rejected as already complete.
// Every command yields exactly one transaction on result_o, in order.
// A clear writes one table entry per cycle; a rejected edge goes straight to its result.
// A checked edge walks each of its two cells up to that cell's root, then walks the same path
// again to point every node on it straight at the root; when two roots of equal rank are
// joined, the surviving root's rank is also raised. The table has a single read and a single
// write port. item_i is ready only while no command is in flight.
// Reset: rows_q and cols_q return to 33 and the block runs a clearing sweep of all 1024 table
// entries, with item_i not ready, and produces no result for it.
// Stalls: the result sits in an output register; a new command is accepted while it waits,
// and the next result is held inside the engine until the output register frees up.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is for the user to write only while the
// block is idle; the block itself does not enforce this.
module maze_spanning_tree_union_find import msuf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  msuf_item_if.sink          item_i,
  msuf_result_if.source      result_o
);

  logic [DIM_W-1:0]  rows_q, cols_q;
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic [DIM_W-1:0]  rows_m1, cols_m1;
  logic [NEED_W-1:0] cell_total;
  logic [NEED_W-1:0] need;

  logic [DIM_W-1:0]  r_ext, c_ext, tr, tc;
  logic              ok;
  cmd_t              cmd;

  logic              start;
  logic              idle;
  logic              out_free;
  logic              res_valid;
  res_t              res;
  logic              out_valid_q;
  res_t              out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROWS: rows_q <= cfg_data_i;
        REG_COLS: cols_q <= cfg_data_i;
        default:  rows_q <= rows_q;
      endcase
    end
  end

  // Saturate the grid size and derive the number of joins that completes the tree.
  always_comb begin
    rows_eff = rows_q;
    if (rows_q < DIM_MIN) begin
      rows_eff = DIM_MIN;
    end else if (rows_q > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end
    cols_eff = cols_q;
    if (cols_q < DIM_MIN) begin
      cols_eff = DIM_MIN;
    end else if (cols_q > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end
  end

  assign rows_m1    = rows_eff - DIM_W'(1);
  assign cols_m1    = cols_eff - DIM_W'(1);
  assign cell_total = NEED_W'(rows_m1[DIM_W-1:1]) * NEED_W'(cols_m1[DIM_W-1:1]);
  assign need       = cell_total - NEED_W'(1);

  // Edge decode: target cell, range check and opened wall.
  assign r_ext = DIM_W'(item_i.cell_row);
  assign c_ext = DIM_W'(item_i.cell_col);
  assign tr    = item_i.go_down ? r_ext + STEP : r_ext;
  assign tc    = item_i.go_down ? c_ext : c_ext + STEP;
  assign ok    = item_i.cell_row[0] && item_i.cell_col[0] &&
                 (r_ext < rows_m1) && (c_ext < cols_m1) &&
                 (tr < rows_m1) && (tc < cols_m1);

  always_comb begin
    cmd.clear    = (func_e'(item_i.func) == FN_CLEAR);
    cmd.bad      = !ok;
    cmd.idx_a    = cell_index(item_i.cell_row, item_i.cell_col);
    cmd.idx_b    = cell_index(tr[COORD_W-1:0], tc[COORD_W-1:0]);
    cmd.wall_row = item_i.go_down ? item_i.cell_row + COORD_W'(1) : item_i.cell_row;
    cmd.wall_col = item_i.go_down ? item_i.cell_col : item_i.cell_col + COORD_W'(1);
  end

  assign item_i.ready = idle;
  assign start        = item_i.valid && idle;
  assign out_free     = !out_valid_q || result_o.ready;

  msuf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .need_i      (need),
    .out_free_i  (out_free),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_q.status;
  assign result_o.wall_row     = out_q.wall_row;
  assign result_o.wall_col     = out_q.wall_col;
  assign result_o.joined_total = out_q.joined_total;
  assign result_o.tree_done    = out_q.tree_done;

endmodule
